@@ rtl/core/esc_throttle_mode_fsm_top_defines.svh @@
// Assertion macros used by the checker file etmf_checker.sv.
`ifndef ESC_THROTTLE_MODE_FSM_TOP_DEFINES_SVH
`define ESC_THROTTLE_MODE_FSM_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ETMF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("etmf check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ETMF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("etmf check failed");

`endif

@@ rtl/core/etmf_pkg.sv @@
package etmf_pkg;

	typedef logic [2:0] mode_t;
	typedef logic [1:0] cfg_idx_t;

	localparam mode_t M_UNDEF = 3'd0;
	localparam mode_t M_INIT  = 3'd1;
	localparam mode_t M_NOSIG = 3'd2;
	localparam mode_t M_OFF   = 3'd3;
	localparam mode_t M_FWD   = 3'd4;
	localparam mode_t M_BWD   = 3'd5;

	localparam cfg_idx_t REG_MID  = 2'd0;
	localparam cfg_idx_t REG_DEAD = 2'd1;
	localparam cfg_idx_t REG_FULL = 2'd2;
	localparam cfg_idx_t REG_PWM  = 2'd3;

	localparam logic [15:0] MID_RESET  = 16'd32000;
	localparam logic [15:0] DEAD_RESET = 16'd16000;
	localparam logic [15:0] FULL_RESET = 16'hFFFF;
	localparam logic [15:0] PWM_RESET  = 16'd1023;

	localparam logic [9:0] START_DELAY_TICKS  = 10'd500;
	localparam logic [9:0] CHECK_PERIOD_TICKS = 10'd1000;
	localparam logic [7:0] PKT_THRESHOLD      = 8'd10;

	localparam logic [1:0] BRIDGE_IDLE = 2'd0;
	localparam logic [1:0] BRIDGE_FWD  = 2'd1;
	localparam logic [1:0] BRIDGE_BWD  = 2'd2;

	localparam logic [1:0] BLINK_OFF    = 2'd0;
	localparam logic [1:0] BLINK_STEADY = 2'd1;
	localparam logic [1:0] BLINK_COUNT  = 2'd2;

endpackage

@@ rtl/core/esc_throttle_mode_fsm_top.sv @@
// ESC mode controller. One input beat is one 1 kHz tick carrying throttle_ok,
// throttle_value and packet_count; every input beat yields exactly one output
// beat with mode, mode_changed, duty, duty_write, bridge_mode, blink_kind,
// blink_count and clear_stats.
// Both data channels use valid/stall; in_stall is high while a tick is being
// processed. Configuration writes (cfg_index 0..3: mid, dead, full, pwm_max)
// are taken whenever cfg_valid is high and should be issued only when idle.
// Timing: a tick that does not need the duty divide passes EVAL and then DONE
// after acceptance. A tick that stays in forward below saturation passes EVAL,
// the multiply state MUL and the restoring divider state DIV (one quotient bit
// per cycle) before DONE. The next tick is accepted the cycle after the result
// is loaded into the output register.
// Reset clears the mode to undefined, both tick counters, the bridge setting
// and loads the register defaults. When the receiver stalls, the output beat
// holds; a new tick can still be accepted and processed, and its result waits
// until the output register is free.
module esc_throttle_mode_fsm_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        throttle_ok,
	input  logic [15:0] throttle_value,
	input  logic [7:0]  packet_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  mode,
	output logic        mode_changed,
	output logic [15:0] duty,
	output logic        duty_write,
	output logic [1:0]  bridge_mode,
	output logic [1:0]  blink_kind,
	output logic [2:0]  blink_count,
	output logic        clear_stats,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]  state_q;
	logic [15:0] mid_q, dead_q, full_q, pwm_q;
	logic        ok_q;
	logic [15:0] tv_q;
	logic [7:0]  pk_q;

	etmf_pkg::mode_t mode_q;
	logic [9:0]  mode_ticks_q, period_ticks_q;
	logic [1:0]  bridge_q;

	etmf_pkg::mode_t p_mode_q;
	logic        p_chg_q, p_dwr_q, p_clr_q;
	logic [15:0] p_duty_q;
	logic [1:0]  p_kind_q;
	logic [2:0]  p_cnt_q;

	logic [15:0] d_q, span_q, rem_q, quo_q;
	logic [3:0]  step_q;

	logic        out_valid_q;

	// Evaluation of one tick.
	logic [16:0] fs_sum;
	logic [15:0] fs, bs, span, excess;
	logic        is_fwd, is_bwd, chk, need_div, duty_sat;
	logic [9:0]  mt_inc, pt_inc;
	logic [7:0]  pk_eff;
	etmf_pkg::mode_t m1, m2;
	logic        chg;
	logic [1:0]  kind;
	logic [2:0]  cnt;
	logic [16:0] trial;
	logic        ge;
	logic        out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		fs_sum  = {1'b0, mid_q} + {1'b0, dead_q};
		fs      = fs_sum[16] ? 16'hFFFF : fs_sum[15:0];
		bs      = (mid_q > dead_q) ? (mid_q - dead_q) : 16'd0;
		is_fwd  = ok_q && (tv_q >= fs);
		is_bwd  = ok_q && (tv_q <= bs);
		mt_inc  = mode_ticks_q + 10'd1;
		pt_inc  = period_ticks_q + 10'd1;
		chk     = (pt_inc == etmf_pkg::CHECK_PERIOD_TICKS);
		pk_eff  = chk ? 8'd0 : pk_q;
		m1      = (chk && pk_q == 8'd0) ? etmf_pkg::M_NOSIG : mode_q;
		span    = (full_q > fs) ? (full_q - fs) : 16'd0;
		excess  = tv_q - fs;
		duty_sat = (span == 16'd0) || (excess >= span);
		need_div = 1'b0;
		m2      = m1;
		unique case (m1)
			etmf_pkg::M_UNDEF: begin
				if (mt_inc == etmf_pkg::START_DELAY_TICKS)
					m2 = etmf_pkg::M_INIT;
			end
			etmf_pkg::M_INIT, etmf_pkg::M_NOSIG: begin
				if (pk_eff > etmf_pkg::PKT_THRESHOLD)
					m2 = etmf_pkg::M_OFF;
			end
			etmf_pkg::M_OFF: begin
				if (is_fwd)
					m2 = etmf_pkg::M_FWD;
				else if (is_bwd)
					m2 = etmf_pkg::M_BWD;
			end
			etmf_pkg::M_FWD: begin
				if (!is_fwd)
					m2 = etmf_pkg::M_OFF;
				else
					need_div = !duty_sat;
			end
			etmf_pkg::M_BWD: begin
				if (!is_bwd)
					m2 = etmf_pkg::M_OFF;
			end
			default: m2 = etmf_pkg::M_UNDEF;
		endcase
		chg  = (m2 != mode_q);
		kind = etmf_pkg::BLINK_OFF;
		cnt  = 3'd0;
		if (chg) begin
			unique case (m2)
				etmf_pkg::M_INIT: begin
					kind = etmf_pkg::BLINK_STEADY;
				end
				etmf_pkg::M_NOSIG: begin
					kind = etmf_pkg::BLINK_COUNT;
					cnt  = 3'd4;
				end
				etmf_pkg::M_OFF: begin
					kind = etmf_pkg::BLINK_COUNT;
					cnt  = 3'd1;
				end
				etmf_pkg::M_FWD: begin
					kind = etmf_pkg::BLINK_COUNT;
					cnt  = 3'd2;
				end
				etmf_pkg::M_BWD: begin
					kind = etmf_pkg::BLINK_COUNT;
					cnt  = 3'd3;
				end
				default: begin
					kind = etmf_pkg::BLINK_OFF;
				end
			endcase
		end
	end

	// One restoring step: shift the next dividend bit into the remainder.
	assign trial = {rem_q, quo_q[15]} - {1'b0, span_q};
	assign ge    = ({rem_q, quo_q[15]} >= {1'b0, span_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q  <= etmf_pkg::MID_RESET;
			dead_q <= etmf_pkg::DEAD_RESET;
			full_q <= etmf_pkg::FULL_RESET;
			pwm_q  <= etmf_pkg::PWM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				etmf_pkg::REG_MID:  mid_q  <= cfg_data;
				etmf_pkg::REG_DEAD: dead_q <= cfg_data;
				etmf_pkg::REG_FULL: full_q <= cfg_data;
				etmf_pkg::REG_PWM:  pwm_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mode_q         <= etmf_pkg::M_UNDEF;
			mode_ticks_q   <= 10'd0;
			period_ticks_q <= 10'd0;
			bridge_q       <= etmf_pkg::BRIDGE_IDLE;
			out_valid_q    <= 1'b0;
			step_q         <= 4'd0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					mode_q         <= m2;
					mode_ticks_q   <= chg ? 10'd0 : mt_inc;
					period_ticks_q <= chk ? 10'd0 : pt_inc;
					if (chg && m2 == etmf_pkg::M_FWD)
						bridge_q <= etmf_pkg::BRIDGE_FWD;
					else if (chg && m2 == etmf_pkg::M_BWD)
						bridge_q <= etmf_pkg::BRIDGE_BWD;
					state_q <= need_div ? ST_MUL : ST_DONE;
				end
				ST_MUL: begin
					step_q  <= 4'd0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'hF)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			ok_q <= throttle_ok;
			tv_q <= throttle_value;
			pk_q <= packet_count;
		end
		if (state_q == ST_EVAL) begin
			p_mode_q <= m2;
			p_chg_q  <= chg;
			p_kind_q <= kind;
			p_cnt_q  <= cnt;
			p_clr_q  <= chk;
			p_dwr_q  <= (m1 == etmf_pkg::M_FWD) && is_fwd;
			p_duty_q <= ((m1 == etmf_pkg::M_FWD) && is_fwd && duty_sat) ? pwm_q : 16'd0;
			d_q      <= excess;
			span_q   <= span;
		end
		if (state_q == ST_MUL)
			{rem_q, quo_q} <= {16'd0, d_q} * {16'd0, pwm_q};
		if (state_q == ST_DIV) begin
			rem_q <= ge ? trial[15:0] : {rem_q[14:0], quo_q[15]};
			quo_q <= {quo_q[14:0], ge};
			if (step_q == 4'hF)
				p_duty_q <= {quo_q[14:0], ge};
		end
		if (state_q == ST_DONE && out_free) begin
			mode         <= p_mode_q;
			mode_changed <= p_chg_q;
			duty         <= p_duty_q;
			duty_write   <= p_dwr_q;
			bridge_mode  <= bridge_q;
			blink_kind   <= p_kind_q;
			blink_count  <= p_cnt_q;
			clear_stats  <= p_clr_q;
		end
	end

endmodule

@@ rtl/core/etmf_checker.sv @@
`include "esc_throttle_mode_fsm_top_defines.svh"

module etmf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  mode,
	input logic        mode_changed,
	input logic        duty_write,
	input logic [1:0]  blink_kind,
	input logic [2:0]  blink_count
);

	// A held output beat stays valid until it is taken.
	`ETMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// After a tick is accepted the block is busy with it.
	`ETMF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// The LED command is issued only together with a mode change.
	`ETMF_ASSERT_NOW(a_blink_on_change, out_valid && !mode_changed,
		blink_kind == etmf_pkg::BLINK_OFF && blink_count == 3'd0)

	// Duty is written only on a tick that stays in forward.
	`ETMF_ASSERT_NOW(a_duty_in_fwd, out_valid && duty_write,
		mode == etmf_pkg::M_FWD && !mode_changed)

endmodule

bind esc_throttle_mode_fsm_top etmf_checker u_etmf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.mode         (mode),
	.mode_changed (mode_changed),
	.duty_write   (duty_write),
	.blink_kind   (blink_kind),
	.blink_count  (blink_count)
);
